// File: sv/whp_pkg.sv
// ----------------------------------------------------------------------------
// whp_pkg
// Shared types, constants and the Whirlpool round functions.
// ----------------------------------------------------------------------------
package whp_pkg;

   localparam int ROUNDS = 10;
   localparam int RND_W  = $clog2(ROUNDS + 1);

   typedef logic [63:0] lane_type;
   typedef lane_type [7:0] state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_START,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic       take_word;   // store request word (already formatted)
      logic       pad_zero;    // store a zero word
      logic       pad_len;     // store the bit count word
      logic       start;       // load key/state from chain and block
      logic       round;       // run one round
      logic       finish;      // fold result into chain
      logic       clear;       // reset chain, fill and bit count
      logic       emit_shift;  // advance output word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0]       fill;
      logic [RND_W-1:0] rnd;
      logic             full_tail; // request word carries eight bytes
   } sts_type;

   localparam logic [7:0] SBOX [256] = '{
    8'h18,8'h23,8'hC6,8'hE8,8'h87,8'hB8,8'h01,8'h4F,8'h36,8'hA6,8'hD2,8'hF5,8'h79,8'h6F,8'h91,8'h52,
    8'h60,8'hBC,8'h9B,8'h8E,8'hA3,8'h0C,8'h7B,8'h35,8'h1D,8'hE0,8'hD7,8'hC2,8'h2E,8'h4B,8'hFE,8'h57,
    8'h15,8'h77,8'h37,8'hE5,8'h9F,8'hF0,8'h4A,8'hDA,8'h58,8'hC9,8'h29,8'h0A,8'hB1,8'hA0,8'h6B,8'h85,
    8'hBD,8'h5D,8'h10,8'hF4,8'hCB,8'h3E,8'h05,8'h67,8'hE4,8'h27,8'h41,8'h8B,8'hA7,8'h7D,8'h95,8'hD8,
    8'hFB,8'hEE,8'h7C,8'h66,8'hDD,8'h17,8'h47,8'h9E,8'hCA,8'h2D,8'hBF,8'h07,8'hAD,8'h5A,8'h83,8'h33,
    8'h63,8'h02,8'hAA,8'h71,8'hC8,8'h19,8'h49,8'hD9,8'hF2,8'hE3,8'h5B,8'h88,8'h9A,8'h26,8'h32,8'hB0,
    8'hE9,8'h0F,8'hD5,8'h80,8'hBE,8'hCD,8'h34,8'h48,8'hFF,8'h7A,8'h90,8'h5F,8'h20,8'h68,8'h1A,8'hAE,
    8'hB4,8'h54,8'h93,8'h22,8'h64,8'hF1,8'h73,8'h12,8'h40,8'h08,8'hC3,8'hEC,8'hDB,8'hA1,8'h8D,8'h3D,
    8'h97,8'h00,8'hCF,8'h2B,8'h76,8'h82,8'hD6,8'h1B,8'hB5,8'hAF,8'h6A,8'h50,8'h45,8'hF3,8'h30,8'hEF,
    8'h3F,8'h55,8'hA2,8'hEA,8'h65,8'hBA,8'h2F,8'hC0,8'hDE,8'h1C,8'hFD,8'h4D,8'h92,8'h75,8'h06,8'h8A,
    8'hB2,8'hE6,8'h0E,8'h1F,8'h62,8'hD4,8'hA8,8'h96,8'hF9,8'hC5,8'h25,8'h59,8'h84,8'h72,8'h39,8'h4C,
    8'h5E,8'h78,8'h38,8'h8C,8'hD1,8'hA5,8'hE2,8'h61,8'hB3,8'h21,8'h9C,8'h1E,8'h43,8'hC7,8'hFC,8'h04,
    8'h51,8'h99,8'h6D,8'h0D,8'hFA,8'hDF,8'h7E,8'h24,8'h3B,8'hAB,8'hCE,8'h11,8'h8F,8'h4E,8'hB7,8'hEB,
    8'h3C,8'h81,8'h94,8'hF7,8'hB9,8'h13,8'h2C,8'hD3,8'hE7,8'h6E,8'hC4,8'h03,8'h56,8'h44,8'h7F,8'hA9,
    8'h2A,8'hBB,8'hC1,8'h53,8'hDC,8'h0B,8'h9D,8'h6C,8'h31,8'h74,8'hF6,8'h46,8'hAC,8'h89,8'h14,8'hE1,
    8'h16,8'h3A,8'h69,8'h09,8'h70,8'hB6,8'hD0,8'hED,8'hCC,8'h42,8'h98,8'hA4,8'h28,8'h5C,8'hF8,8'h86
   };

   localparam logic [7:0] CIRC [8] = '{8'h01,8'h01,8'h04,8'h01,8'h08,8'h05,8'h02,8'h09};

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = a[7] ? ({a[6:0], 1'b0} ^ 8'h1D) : {a[6:0], 1'b0};
   endfunction

   // multiply by a constant of at most four bits
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r, x2, x4, x8;
      x2 = xtime(a);
      x4 = xtime(x2);
      x8 = xtime(x4);
      r = (b[0] ? a : 8'h00) ^ (b[1] ? x2 : 8'h00) ^ (b[2] ? x4 : 8'h00)
        ^ (b[3] ? x8 : 8'h00);
      gmul = r;
   endfunction

   // gamma, pi and theta on the whole 512-bit state
   function automatic state_type round_core(input state_type s);
      state_type  o;
      logic [7:0] g [8][8];
      logic [7:0] acc;
      for (int i = 0; i < 8; i++) begin
         for (int t = 0; t < 8; t++) begin
            g[i][t] = SBOX[s[(i - t) & 7][(56 - 8 * t) +: 8]];
         end
      end
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            acc = 8'h00;
            for (int t = 0; t < 8; t++) begin
               acc = acc ^ gmul(g[i][t], CIRC[(j - t) & 7]);
            end
            o[i][(56 - 8 * j) +: 8] = acc;
         end
      end
      round_core = o;
   endfunction

   function automatic lane_type round_const(input logic [RND_W-1:0] r);
      lane_type c;
      for (int i = 0; i < 8; i++) begin
         c[(56 - 8 * i) +: 8] = SBOX[(8 * int'(r) + i) & 255];
      end
      round_const = c;
   endfunction

endpackage

// File: sv/whp_ctrl.sv
// ----------------------------------------------------------------------------
// whp_ctrl
// Sequencer: word intake, padding, round count and digest output.
// ----------------------------------------------------------------------------
module whp_ctrl
   import whp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  logic    eom,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output logic    rsp_tlast,
   output cmd_type cmd,
   input  sts_type sts
);

   fsm_type    state_ff, state_in;
   logic       final_ff, final_in;     // compression belongs to message end
   logic       lenpend_ff, lenpend_in; // padding still owes the length word
   logic       spill_ff, spill_in;     // length goes into the next block
   logic [2:0] ocnt_ff, ocnt_in;

   wire take = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      final_in   = final_ff;
      lenpend_in = lenpend_ff;
      spill_in   = spill_ff;
      ocnt_in    = ocnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (eom) begin
                  final_in   = 1'b1;
                  lenpend_in = 1'b1;
                  // tail (and 0x80 word) leave no room for the length field
                  spill_in   = sts.full_tail ? (sts.fill inside {[3'd3:3'd6]})
                                             : (sts.fill inside {[3'd4:3'd6]});
                  // last word closes the block: compress before padding
                  state_in   = (sts.fill == 3'd7) ? ST_START : ST_PAD;
               end else if (sts.fill == 3'd7) begin
                  state_in = ST_START;
               end
            end
         end
         ST_PAD: begin
            if (sts.fill == 3'd7) begin
               state_in   = ST_START;
               lenpend_in = lenpend_ff && spill_ff;
               spill_in   = 1'b0;
            end
         end
         ST_START: state_in = ST_ROUND;
         ST_ROUND: begin
            if (sts.rnd == RND_W'(ROUNDS - 1)) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            if (final_ff && !lenpend_ff) begin
               state_in = ST_EMIT;
               ocnt_in  = 3'd0;
            end else if (final_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               ocnt_in = ocnt_ff + 3'd1;
               if (ocnt_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  final_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.take_word = take;
         end
         ST_PAD: begin
            cmd.pad_len  = (sts.fill == 3'd7) && lenpend_ff && !spill_ff;
            cmd.pad_zero = !cmd.pad_len;
         end
         ST_START: cmd.start  = 1'b1;
         ST_ROUND: cmd.round  = 1'b1;
         ST_FINAL: cmd.finish = 1'b1;
         ST_EMIT: begin
            rsp_tvalid     = 1'b1;
            rsp_tlast      = (ocnt_ff == 3'd7);
            cmd.emit_shift = rsp_tready;
            cmd.clear      = rsp_tready && (ocnt_ff == 3'd7);
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         final_ff   <= 1'b0;
         lenpend_ff <= 1'b0;
         spill_ff   <= 1'b0;
         ocnt_ff    <= 3'd0;
      end else begin
         state_ff   <= state_in;
         final_ff   <= final_in;
         lenpend_ff <= lenpend_in;
         spill_ff   <= spill_in;
         ocnt_ff    <= ocnt_in;
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input accepted while busy");
   a_emit_after_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_FINAL)
      else $error("digest started without compression");
   a_last_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> state_ff == ST_IDLE)
      else $error("digest did not end");

endmodule

// File: sv/whp_dpath.sv
// ----------------------------------------------------------------------------
// whp_dpath
// Block buffer, bit count, round unit (one round per cycle) and chain value.
// ----------------------------------------------------------------------------
module whp_dpath
   import whp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] msg_word,
   input  logic [3:0]  byte_count,
   input  logic        eom,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [63:0] digest_word
);

   state_type        blk_ff, blk_in;
   state_type        chain_ff, chain_in;
   state_type        key_ff, key_in;
   state_type        st_ff, st_in;
   logic [2:0]       fill_ff, fill_in;
   logic [63:0]      bits_ff, bits_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic             extra_ff, extra_in; // 0x80 word still owed after a full last word

   logic [3:0]  cnt;
   logic [63:0] mask, wfmt, wstore;
   state_type   key_nxt, st_core;

   always_comb begin
      cnt  = (byte_count > 4'd8) ? 4'd8 : byte_count;
      mask = (cnt == 4'd8) ? '1 : ~({64{1'b1}} >> (7'(cnt) * 7'd8));
      wfmt = msg_word & mask;
      if (cnt != 4'd8) wfmt = wfmt | (64'h80 << (7'd56 - 7'(cnt) * 7'd8));
      wstore = (cmd.take_word && eom) ? wfmt : msg_word;
   end

   always_comb begin
      key_nxt    = round_core(key_ff);
      key_nxt[0] = key_nxt[0] ^ round_const(rnd_ff);
      st_core    = round_core(st_ff);
   end

   always_comb begin
      blk_in   = blk_ff;
      chain_in = chain_ff;
      key_in   = key_ff;
      st_in    = st_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      rnd_in   = rnd_ff;
      extra_in = extra_ff;
      if (cmd.take_word) begin
         blk_in[fill_ff] = wstore;
         fill_in         = fill_ff + 3'd1;
         bits_in = bits_ff + (eom ? {57'd0, cnt, 3'd0} : 64'd64);
         extra_in = eom && (cnt == 4'd8);
      end
      if (cmd.pad_zero || cmd.pad_len) begin
         blk_in[fill_ff] = cmd.pad_len ? bits_ff : (extra_ff ? 64'h80 << 56 : 64'd0);
         fill_in         = fill_ff + 3'd1;
         extra_in        = 1'b0;
      end
      if (cmd.start) begin
         key_in = chain_ff;
         for (int i = 0; i < 8; i++) st_in[i] = blk_ff[i] ^ chain_ff[i];
         rnd_in = '0;
      end
      if (cmd.round) begin
         key_in = key_nxt;
         for (int i = 0; i < 8; i++) st_in[i] = st_core[i] ^ key_nxt[i];
         rnd_in = rnd_ff + RND_W'(1);
      end
      if (cmd.finish) begin
         for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] ^ st_ff[i] ^ blk_ff[i];
      end
      if (cmd.emit_shift) begin
         for (int i = 0; i < 7; i++) chain_in[i] = chain_ff[i + 1];
         chain_in[7] = chain_ff[0];
      end
      if (cmd.clear) begin
         chain_in = '0;
         fill_in  = 3'd0;
         bits_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
         fill_ff  <= 3'd0;
         bits_ff  <= '0;
         rnd_ff   <= '0;
         extra_ff <= 1'b0;
      end else begin
         chain_ff <= chain_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         rnd_ff   <= rnd_in;
         extra_ff <= extra_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      key_ff <= key_in;
      st_ff  <= st_in;
   end

   assign sts.fill      = fill_ff;
   assign sts.rnd       = rnd_ff;
   assign sts.full_tail = (cnt == 4'd8);
   assign digest_word   = chain_ff[0];

   a_fill_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> fill_ff == 3'd0 && bits_ff == 64'd0)
      else $error("clear did not reset counters");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      cmd.round |-> rnd_ff < RND_W'(ROUNDS))
      else $error("round count overrun");
   a_start_rnd: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> rnd_ff == '0)
      else $error("round count not reset");

endmodule

// File: sv/whirlpool_hash_512.sv
// ----------------------------------------------------------------------------
// whirlpool_hash_512
// Streaming Whirlpool-512 hasher with on-chip padding and length field.
// ----------------------------------------------------------------------------
// One input word is taken per cycle while no block is compressing. The eighth
// word of a block starts a compression (load, ten rounds through a single
// round unit, fold into the chain). At end of message padding words and one
// or two compressions follow, then eight digest words leave on rsp_, digest
// word 0 first, rsp_tlast on word 7.
module whirlpool_hash_512
   import whp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // msg_word[63:0], byte_count[67:64], zero
   input  logic        req_tlast,  // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // digest_word
   output logic        rsp_tlast   // digest_last
);

   cmd_type cmd;
   sts_type sts;

   whp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .eom        (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

   whp_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .msg_word    (req_tdata[63:0]),
      .byte_count  (req_tdata[67:64]),
      .eom         (req_tlast),
      .cmd         (cmd),
      .sts         (sts),
      .digest_word (rsp_tdata)
   );

   wire unused_pad = ^req_tdata[71:68];

   a_tlast_on_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tlast |-> rsp_tvalid)
      else $error("tlast without valid");

endmodule

// File: tb/whirlpool_hash_512_checker.sv
// ----------------------------------------------------------------------------
// whirlpool_hash_512_checker
// Watches the message and digest streams, hashes every accepted message word
// with its own Whirlpool model and compares each digest word in order.
// ----------------------------------------------------------------------------
module whirlpool_hash_512_checker
   import whp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,  // msg_word[63:0], byte_count[67:64], zero
   input  logic        req_tlast,  // end_of_message
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,  // digest_word
   input  logic        rsp_tlast,  // digest_last
   output int          fail_count,
   output int          pending
);

   typedef struct {
      lane_type digest;
      logic     last;
   } digest_word_type;

   digest_word_type digest_fifo[$];

   lane_type  mix_tbl [256];
   state_type chain;
   state_type blk;
   int        fill;
   lane_type  bit_len;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) r = r ^ a;
         a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1D) : {a[6:0], 1'b0};
      end
      return r;
   endfunction

   initial begin
      logic [7:0] coef [8];
      coef = '{8'h01, 8'h01, 8'h04, 8'h01, 8'h08, 8'h05, 8'h02, 8'h09};
      for (int x = 0; x < 256; x++) begin
         for (int j = 0; j < 8; j++) begin
            mix_tbl[x][(56 - 8 * j) +: 8] = gf_mul(SBOX[x], coef[j]);
         end
      end
   end

   // gamma, pi and theta through the combined column table
   function automatic state_type whirl_round(input state_type s);
      state_type o;
      lane_type  v;
      for (int i = 0; i < 8; i++) begin
         o[i] = '0;
         for (int t = 0; t < 8; t++) begin
            v = mix_tbl[s[(i - t) & 7][(56 - 8 * t) +: 8]];
            o[i] = o[i] ^ ((t == 0) ? v : ((v >> (8 * t)) | (v << (64 - 8 * t))));
         end
      end
      return o;
   endfunction

   task automatic compress_block();
      state_type key, st;
      lane_type  rc;
      key = chain;
      for (int i = 0; i < 8; i++) st[i] = blk[i] ^ key[i];
      for (int r = 0; r < ROUNDS; r++) begin
         for (int i = 0; i < 8; i++) rc[(56 - 8 * i) +: 8] = SBOX[8 * r + i];
         key = whirl_round(key);
         key[0] = key[0] ^ rc;
         st = whirl_round(st);
         for (int i = 0; i < 8; i++) st[i] = st[i] ^ key[i];
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] ^ st[i] ^ blk[i];
   endtask

   task automatic store_word(input lane_type w);
      blk[fill] = w;
      fill++;
      if (fill == 8) begin
         compress_block();
         fill = 0;
      end
   endtask

   task automatic hash_word(input lane_type w, input logic [3:0] cnt_in, input logic eom);
      int       cnt;
      lane_type pw;
      if (!eom) begin
         bit_len += 64;
         store_word(w);
         return;
      end
      cnt = (cnt_in > 8) ? 8 : int'(cnt_in);
      bit_len += 64'(cnt * 8);
      if (cnt == 8) begin
         store_word(w);
         store_word(64'h80 << 56);
      end else begin
         pw = (cnt == 0) ? '0 : (w & (~64'h0 << (64 - 8 * cnt)));
         store_word(pw | (64'h80 << (56 - 8 * cnt)));
      end
      // length field does not fit: close this block first
      if (fill > 4) while (fill != 0) store_word('0);
      while (fill < 7) store_word('0);
      store_word(bit_len);
      for (int k = 0; k < 8; k++) digest_fifo.push_back('{chain[k], k == 7});
      chain   = '0;
      fill    = 0;
      bit_len = '0;
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      digest_word_type exp_w;
      if (reset) begin
         chain   = '0;
         blk     = '0;
         fill    = 0;
         bit_len = '0;
         digest_fifo.delete();
      end else begin
         if (req_tvalid && req_tready)
            hash_word(req_tdata[63:0], req_tdata[67:64], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (digest_fifo.size() == 0) begin
               report_mismatch($sformatf("unexpected digest word %h", rsp_tdata));
            end else begin
               exp_w = digest_fifo.pop_front();
               if (rsp_tdata !== exp_w.digest)
                  report_mismatch($sformatf("digest %h, expected %h", rsp_tdata,
                                            exp_w.digest));
               if (rsp_tlast !== exp_w.last)
                  report_mismatch($sformatf("tlast %b, expected %b", rsp_tlast,
                                            exp_w.last));
            end
         end
      end
      pending <= digest_fifo.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end

endmodule

// File: tb/whirlpool_hash_512_tb.sv
// ----------------------------------------------------------------------------
// whirlpool_hash_512_tb
// Sends directed and random messages with random gaps and back-pressure;
// the checker hashes them independently and compares every digest word.
// ----------------------------------------------------------------------------
module whirlpool_hash_512_tb
   import whp_pkg::*;
();

   localparam int NUM_ITEMS   = 330;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;  // msg_word[63:0], byte_count[67:64], zero
   logic        req_tlast;  // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;  // digest_word
   logic        rsp_tlast;  // digest_last

   int fail_count;
   int pending;
   int cycles;
   int words_sent;
   bit calm;

   whirlpool_hash_512 u_top (.*);

   whirlpool_hash_512_checker u_checker (.*);

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 28);
   end

   // valid stays up after the handshake; the next call drives or drops it
   task automatic send_word(input lane_type w, input logic [3:0] cnt, input logic eom);
      bit took;
      if (!calm) begin
         while ($urandom_range(99) < 28) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, cnt, w};
      req_tlast  <= eom;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      words_sent++;
   endtask

   function automatic lane_type rand_lane();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_message(input int nwords, input logic [3:0] last_cnt);
      for (int i = 0; i < nwords; i++)
         send_word(rand_lane(), 4'($urandom_range(15)), 1'b0);
      send_word(rand_lane(), last_cnt, 1'b1);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      int nw;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      cycles     = 0;
      words_sent = 0;
      calm       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message, then a single full final word of ones
      send_word('0, 4'd0, 1'b1);
      send_word('1, 4'd8, 1'b1);
      // 32 bytes already held: padding needs a second block
      for (int i = 0; i < 4; i++) send_word('1, 4'd15, 1'b0);
      send_word('1, 4'd0, 1'b1);
      // 31 bytes: length still fits
      for (int i = 0; i < 3; i++) send_word('0, 4'd0, 1'b0);
      send_word('1, 4'd7, 1'b1);
      // over-range counts on the final word
      send_word('1, 4'd15, 1'b1);
      send_word(rand_lane(), 4'd9, 1'b1);
      // final word fills a block exactly
      for (int i = 0; i < 7; i++) send_word(rand_lane(), 4'($urandom_range(15)), 1'b0);
      send_word(rand_lane(), 4'd8, 1'b1);
      send_word(rand_lane(), 4'd1, 1'b1);
      // hold off until every digest has come out
      wait_drained();

      while (words_sent < NUM_ITEMS) begin
         calm = (words_sent > 150 && words_sent < 220);
         nw = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(9);
         send_message(nw, 4'($urandom_range(1) ? $urandom_range(8) : $urandom_range(15)));
      end
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
